>>> hdl/crc8_checked_command_frame_parser_top_macros.svh
// Assertion macros for the command frame parser.
// Used by crc8_checked_command_frame_parser_top; expects ports named clock and reset.
`ifndef CRC8_CHECKED_COMMAND_FRAME_PARSER_TOP_MACROS_SVH
`define CRC8_CHECKED_COMMAND_FRAME_PARSER_TOP_MACROS_SVH

`ifndef SYNTH
`define CFP_ASSERT(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed in frame parser");
`define CFP_ASSERT_ALWAYS(name, prop) \
   name: assert property (@(posedge clock) prop) \
      else $error("assertion failed in frame parser, reset included");
`else
`define CFP_ASSERT(name, prop)
`define CFP_ASSERT_ALWAYS(name, prop)
`endif

`endif

>>> hdl/cfp_pkg.sv
// Package for the command frame parser: word types, constants and helper functions.
// No dependencies; used by crc8_checked_command_frame_parser_top.
`timescale 1ns / 1ps

package cfp_pkg;

   localparam int CMD_MAX  = 8;
   localparam int TYPE_CAP = 7;
   localparam int TYPE_LIMIT = (CMD_MAX - 1 < TYPE_CAP) ? CMD_MAX - 1 : TYPE_CAP;

   localparam logic [7:0]  CRC_POLY = 8'h8C;
   localparam logic [7:0]  CRC_INIT = 8'h00;
   // The four bytes ",CRC" as they sit in the window, oldest byte highest.
   localparam logic [31:0] TAG_HEAD = 32'h2C43_5243;
   localparam logic [31:0] SEQ_SAT  = 32'h8000_0000;
   localparam logic [31:0] SEQ_MAX  = 32'h7FFF_FFFF;

   localparam logic [7:0] TYPE_KEY [5] = '{8'h54, 8'h59, 8'h50, 8'h45, 8'h3D};
   localparam logic [7:0] SEQ_KEY  [4] = '{8'h53, 8'h45, 8'h51, 8'h3D};

   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_EQUALS = 8'h3D;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       frame_end;
   } req_type;

   typedef struct packed {
      logic               frame_ok;
      logic               tag_seen;
      logic [7:0]         crc_computed;
      logic [7:0]         crc_received;
      logic [55:0]        cmd_text;
      logic [2:0]         cmd_len;
      logic signed [31:0] seq_number;
   } rsp_type;

   // Reflected CRC-8 update over one byte, least significant bit first.
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc;
      for (int k = 0; k < 8; k++) begin
         if (c[0] ^ data[k]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   // Returns a valid flag in the top bit and the digit value below it.
   function automatic logic [4:0] hex_digit(input logic [7:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, 4'(b - 8'h30)};
      end else if (b >= 8'h61 && b <= 8'h66) begin
         r = {1'b1, 4'(b - 8'h57)};
      end else if (b >= 8'h41 && b <= 8'h46) begin
         r = {1'b1, 4'(b - 8'h37)};
      end
      return r;
   endfunction

   function automatic logic is_blank(input logic [7:0] b);
      return (b == CHAR_SPACE) || (b >= 8'h09 && b <= 8'h0D);
   endfunction

   function automatic logic is_decimal(input logic [7:0] b);
      return (b >= 8'h30 && b <= 8'h39);
   endfunction

   // Accumulator times ten plus the digit, with the magnitude held at 2^31.
   function automatic logic [31:0] seq_step(input logic [31:0] acc, input logic [7:0] b);
      logic [35:0] m;
      m = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {32'd0, 4'(b - 8'h30)};
      return (m > {4'd0, SEQ_SAT}) ? SEQ_SAT : m[31:0];
   endfunction

endpackage

>>> hdl/crc8_checked_command_frame_parser_top.sv
// Command frame parser with CRC-8 check. Frame bytes arrive one word per clock on the req
// channel while the input does not stall, frame_end set on the last byte; for that byte
// exactly one result word leaves on the rsp channel, nothing for the others. A byte is
// taken into an input register and, once it advances, it updates the frame state (CRC
// window, tag, TYPE and SEQ matchers) and, on the final byte, loads the result register;
// a final byte waits in the input register while the previous result is still held. The
// block takes one word every clock unless the input stalls; this rests on a state update
// that is one combinational pass (one unrolled CRC byte step and the sequence multiply-add).
// The input stalls only when a final byte is held behind a result that is not yet taken.
`timescale 1ns / 1ps
`include "crc8_checked_command_frame_parser_top_macros.svh"

module crc8_checked_command_frame_parser_top (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  cfp_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output cfp_pkg::rsp_type rsp_data
);

   localparam logic [1:0] TYPE_SEARCH  = 2'd0;
   localparam logic [1:0] TYPE_CAPTURE = 2'd1;
   localparam logic [1:0] TYPE_DONE    = 2'd2;

   localparam logic [2:0] SEQ_SEARCH = 3'd0;
   localparam logic [2:0] SEQ_BLANKS = 3'd1;
   localparam logic [2:0] SEQ_SIGN   = 3'd2;
   localparam logic [2:0] SEQ_DIGITS = 3'd3;
   localparam logic [2:0] SEQ_DONE   = 3'd4;

   // Input register.
   logic             in_valid_ff, in_valid_in;
   cfp_pkg::req_type in_data_ff, in_data_in;
   logic             advance;
   logic [7:0]       b;

   // Frame state.
   logic        first_pending_ff, first_pending_in;
   logic        start_good_ff, start_good_in;
   logic [31:0] tag_window_ff, tag_window_in;
   logic [2:0]  window_fill_ff, window_fill_in;
   logic [7:0]  crc_ff, crc_in;
   logic        tag_found_ff, tag_found_in;
   logic        hex_active_ff, hex_active_in;
   logic [7:0]  hex_value_ff, hex_value_in;
   logic [2:0]  type_match_pos_ff, type_match_pos_in;
   logic [1:0]  type_phase_ff, type_phase_in;
   logic [55:0] type_buffer_ff, type_buffer_in;
   logic [3:0]  type_count_ff, type_count_in;
   logic [2:0]  seq_match_pos_ff, seq_match_pos_in;
   logic [2:0]  seq_phase_ff, seq_phase_in;
   logic [31:0] seq_accum_ff, seq_accum_in;
   logic        seq_negative_ff, seq_negative_in;
   logic        seq_nonempty_ff, seq_nonempty_in;

   // Result register.
   logic             rsp_valid_ff, rsp_valid_in;
   cfp_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [4:0]  hex_d;
   logic        type_ok;
   logic        seq_ok;
   logic [31:0] seq_value;

   assign b         = in_data_ff.in_byte;
   assign advance   = in_valid_ff && !(in_data_ff.frame_end && rsp_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign hex_d     = cfp_pkg::hex_digit(b);

   always_comb begin
      in_data_in  = in_data_ff;
      in_valid_in = in_valid_ff;
      if (req_valid && !req_stall) begin
         in_data_in  = req_data;
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      first_pending_in  = first_pending_ff;
      start_good_in     = start_good_ff;
      tag_window_in     = tag_window_ff;
      window_fill_in    = window_fill_ff;
      crc_in            = crc_ff;
      tag_found_in      = tag_found_ff;
      hex_active_in     = hex_active_ff;
      hex_value_in      = hex_value_ff;
      type_match_pos_in = type_match_pos_ff;
      type_phase_in     = type_phase_ff;
      type_buffer_in    = type_buffer_ff;
      type_count_in     = type_count_ff;
      seq_match_pos_in  = seq_match_pos_ff;
      seq_phase_in      = seq_phase_ff;
      seq_accum_in      = seq_accum_ff;
      seq_negative_in   = seq_negative_ff;
      seq_nonempty_in   = seq_nonempty_ff;

      if (advance) begin
         if (first_pending_ff) begin
            start_good_in    = (b == cfp_pkg::CHAR_DOLLAR);
            first_pending_in = 1'b0;
         end

         if (hex_active_ff) begin
            if (hex_d[4]) begin
               hex_value_in = {hex_value_ff[3:0], hex_d[3:0]};
            end else begin
               hex_active_in = 1'b0;
            end
         end

         // The window holds the last four bytes back from the CRC until the tag is ruled out.
         if (!tag_found_ff) begin
            if (window_fill_ff[2]) begin
               if (tag_window_ff == cfp_pkg::TAG_HEAD && b == cfp_pkg::CHAR_EQUALS) begin
                  tag_found_in  = 1'b1;
                  hex_active_in = 1'b1;
               end else begin
                  crc_in        = cfp_pkg::crc8_byte(crc_ff, tag_window_ff[31:24]);
                  tag_window_in = {tag_window_ff[23:0], b};
               end
            end else begin
               tag_window_in  = {tag_window_ff[23:0], b};
               window_fill_in = window_fill_ff + 3'd1;
            end
         end

         unique case (type_phase_ff)
            TYPE_CAPTURE: begin
               if (b == cfp_pkg::CHAR_COMMA) begin
                  type_phase_in = TYPE_DONE;
               end else begin
                  for (int i = 0; i < cfp_pkg::TYPE_CAP; i++) begin
                     if (type_count_ff == 4'(i)) begin
                        type_buffer_in[8*i +: 8] = b;
                     end
                  end
                  if (type_count_ff != 4'd15) begin
                     type_count_in = type_count_ff + 4'd1;
                  end
               end
            end
            TYPE_SEARCH: begin
               if (type_match_pos_ff < 3'd5 && b == cfp_pkg::TYPE_KEY[type_match_pos_ff]) begin
                  type_match_pos_in = type_match_pos_ff + 3'd1;
               end else begin
                  type_match_pos_in = (b == cfp_pkg::TYPE_KEY[0]) ? 3'd1 : 3'd0;
               end
               if (type_match_pos_in == 3'd5) begin
                  type_phase_in = TYPE_CAPTURE;
               end
            end
            default: begin
            end
         endcase

         unique case (seq_phase_ff)
            SEQ_SEARCH: begin
               if (seq_match_pos_ff < 3'd4 &&
                   b == cfp_pkg::SEQ_KEY[seq_match_pos_ff[1:0]]) begin
                  seq_match_pos_in = seq_match_pos_ff + 3'd1;
               end else begin
                  seq_match_pos_in = (b == cfp_pkg::SEQ_KEY[0]) ? 3'd1 : 3'd0;
               end
               if (seq_match_pos_in == 3'd4) begin
                  seq_phase_in = SEQ_BLANKS;
               end
            end
            SEQ_BLANKS: begin
               if (b != cfp_pkg::CHAR_COMMA) begin
                  seq_nonempty_in = 1'b1;
               end
               if (cfp_pkg::is_blank(b)) begin
                  seq_phase_in = SEQ_BLANKS;
               end else if (b == cfp_pkg::CHAR_PLUS || b == cfp_pkg::CHAR_MINUS) begin
                  seq_negative_in = (b == cfp_pkg::CHAR_MINUS);
                  seq_phase_in    = SEQ_SIGN;
               end else if (cfp_pkg::is_decimal(b)) begin
                  seq_accum_in = cfp_pkg::seq_step(seq_accum_ff, b);
                  seq_phase_in = SEQ_DIGITS;
               end else begin
                  seq_phase_in = SEQ_DONE;
               end
            end
            SEQ_SIGN, SEQ_DIGITS: begin
               if (cfp_pkg::is_decimal(b)) begin
                  seq_accum_in = cfp_pkg::seq_step(seq_accum_ff, b);
                  seq_phase_in = SEQ_DIGITS;
               end else begin
                  seq_phase_in = SEQ_DONE;
               end
            end
            default: begin
            end
         endcase
      end

      type_ok = (type_phase_in != TYPE_SEARCH) && (type_count_in != 4'd0) &&
                (type_count_in <= 4'(cfp_pkg::TYPE_LIMIT));
      seq_ok  = (seq_phase_in != SEQ_SEARCH) && seq_nonempty_in && !seq_negative_in &&
                (seq_accum_in != 32'd0);
      if (seq_negative_in) begin
         seq_value = 32'd0 - seq_accum_in;
      end else begin
         seq_value = seq_accum_in[31] ? cfp_pkg::SEQ_MAX : seq_accum_in;
      end

      rsp_data_in.frame_ok     = start_good_in && tag_found_in && (crc_in == hex_value_in) &&
                                 type_ok && seq_ok;
      rsp_data_in.tag_seen     = tag_found_in;
      rsp_data_in.crc_computed = tag_found_in ? crc_in : 8'd0;
      rsp_data_in.crc_received = tag_found_in ? hex_value_in : 8'd0;
      rsp_data_in.cmd_text     = type_ok ? type_buffer_in : 56'd0;
      rsp_data_in.cmd_len      = type_ok ? type_count_in[2:0] : 3'd0;
      rsp_data_in.seq_number   = $signed(seq_value);

      // Every frame starts from the reset state once its result is taken in.
      if (advance && in_data_ff.frame_end) begin
         first_pending_in  = 1'b1;
         start_good_in     = 1'b0;
         tag_window_in     = 32'd0;
         window_fill_in    = 3'd0;
         crc_in            = cfp_pkg::CRC_INIT;
         tag_found_in      = 1'b0;
         hex_active_in     = 1'b0;
         hex_value_in      = 8'd0;
         type_match_pos_in = 3'd0;
         type_phase_in     = TYPE_SEARCH;
         type_buffer_in    = 56'd0;
         type_count_in     = 4'd0;
         seq_match_pos_in  = 3'd0;
         seq_phase_in      = SEQ_SEARCH;
         seq_accum_in      = 32'd0;
         seq_negative_in   = 1'b0;
         seq_nonempty_in   = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && in_data_ff.frame_end) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         first_pending_ff  <= 1'b1;
         start_good_ff     <= 1'b0;
         tag_window_ff     <= 32'd0;
         window_fill_ff    <= 3'd0;
         crc_ff            <= cfp_pkg::CRC_INIT;
         tag_found_ff      <= 1'b0;
         hex_active_ff     <= 1'b0;
         hex_value_ff      <= 8'd0;
         type_match_pos_ff <= 3'd0;
         type_phase_ff     <= TYPE_SEARCH;
         type_buffer_ff    <= 56'd0;
         type_count_ff     <= 4'd0;
         seq_match_pos_ff  <= 3'd0;
         seq_phase_ff      <= SEQ_SEARCH;
         seq_accum_ff      <= 32'd0;
         seq_negative_ff   <= 1'b0;
         seq_nonempty_ff   <= 1'b0;
      end else begin
         in_valid_ff       <= in_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
         first_pending_ff  <= first_pending_in;
         start_good_ff     <= start_good_in;
         tag_window_ff     <= tag_window_in;
         window_fill_ff    <= window_fill_in;
         crc_ff            <= crc_in;
         tag_found_ff      <= tag_found_in;
         hex_active_ff     <= hex_active_in;
         hex_value_ff      <= hex_value_in;
         type_match_pos_ff <= type_match_pos_in;
         type_phase_ff     <= type_phase_in;
         type_buffer_ff    <= type_buffer_in;
         type_count_ff     <= type_count_in;
         seq_match_pos_ff  <= seq_match_pos_in;
         seq_phase_ff      <= seq_phase_in;
         seq_accum_ff      <= seq_accum_in;
         seq_negative_ff   <= seq_negative_in;
         seq_nonempty_ff   <= seq_nonempty_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff <= in_data_in;
      if (advance && in_data_ff.frame_end) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   `CFP_ASSERT(a_end_loads_result, advance && in_data_ff.frame_end |=> rsp_valid_ff)
   `CFP_ASSERT(a_end_clears_frame, advance && in_data_ff.frame_end |=> first_pending_ff && !tag_found_ff)
   `CFP_ASSERT_ALWAYS(a_tag_needs_full_window, tag_found_ff |-> window_fill_ff == 3'd4)
   `CFP_ASSERT_ALWAYS(a_hex_after_tag, hex_active_ff |-> tag_found_ff)
   `CFP_ASSERT_ALWAYS(a_no_type_chars_in_search, type_phase_ff == TYPE_SEARCH |-> type_count_ff == 4'd0)

endmodule
